FILE: hw/rtl/color_marker_extent_tracker_assert.svh
// ----------------------------------------------------------------------------
// Colour marker extent tracker - assertion macros
// Shared property wrappers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef COLOR_MARKER_EXTENT_TRACKER_ASSERT_SVH
`define COLOR_MARKER_EXTENT_TRACKER_ASSERT_SVH

// Same-cycle implication
`define CMET_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CMET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cmet_pkg.sv
// ----------------------------------------------------------------------------
// cmet_pkg
// Types, limits and colour thresholds of the colour marker extent tracker.
// ----------------------------------------------------------------------------
package cmet_pkg;

  localparam int unsigned CoordW = 10;
  localparam int unsigned LevelW = 8;
  localparam int unsigned StageW = 3;

  // Image limits; pixels at or beyond these get no colour flags
  localparam int unsigned MAX_ROWS = 1024;
  localparam int unsigned MAX_COLS = 1024;
  localparam int unsigned LimW     = 17;

  // Colour thresholds
  localparam logic [LevelW-1:0] HighMin      = LevelW'(100);
  localparam logic [LevelW-1:0] LowMax       = LevelW'(50);
  localparam logic [LevelW-1:0] YelBlueMax   = LevelW'(20);
  localparam logic [LevelW-1:0] PinkMin      = LevelW'(200);
  localparam logic [LevelW-1:0] PinkGreenMax = LevelW'(150);

  // Queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [LevelW-1:0] level_t;

  typedef enum logic [StageW-1:0] {
    StageNone   = 3'd0,
    StageRed    = 3'd1,
    StageGreen  = 3'd2,
    StageYellow = 3'd3,
    StagePink   = 3'd4
  } stage_e;

  typedef struct packed {
    coord_t pixel_row;
    coord_t pixel_col;
    level_t blue_level;
    level_t green_level;
    level_t red_level;
    logic   frame_end;
  } pixel_t;

  typedef struct packed {
    coord_t              red_right_col;
    coord_t              red_top_row;
    coord_t              green_left_col;
    coord_t              green_bottom_row;
    coord_t              yellow_right_col;
    coord_t              yellow_top_row;
    coord_t              pink_left_col;
    coord_t              pink_bottom_row;
    logic [StageW-1:0]   stage_reached;
  } result_t;

  // Classified request handed from front to back
  typedef struct packed {
    coord_t row;
    coord_t col;
    logic   is_red;
    logic   is_green;
    logic   is_yellow;
    logic   is_pink;
    logic   last;
  } entry_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             full;
  } q_stat_t;

endpackage

FILE: hw/rtl/cmet_intf.sv
// ----------------------------------------------------------------------------
// cmet_intf
// Valid/ready channels for pixel requests and extent results.
// ----------------------------------------------------------------------------
interface cmet_pix_if;
  import cmet_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cmet_res_if;
  import cmet_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/cmet_front.sv
// ----------------------------------------------------------------------------
// cmet_front
// Accept pixel requests and classify them into colour flags.
// ----------------------------------------------------------------------------
module cmet_front (
  cmet_pix_if.sink          pix_i,
  input  cmet_pkg::q_stat_t stat_i,
  output logic              push_o,
  output cmet_pkg::entry_t  entry_o
);
  import cmet_pkg::*;

  logic   in_img;
  logic   red, green, yellow;
  pixel_t px;

  assign px = pix_i.data;

  assign pix_i.ready = !stat_i.full;
  assign push_o      = pix_i.valid && !stat_i.full;

  always_comb begin
    in_img = ({{(LimW-CoordW){1'b0}}, px.pixel_row} < LimW'(MAX_ROWS)) &&
             ({{(LimW-CoordW){1'b0}}, px.pixel_col} < LimW'(MAX_COLS));
    red    = (px.red_level >= HighMin) && (px.blue_level < LowMax) &&
             (px.green_level < LowMax);
    green  = !red && (px.green_level >= HighMin) && (px.blue_level < LowMax) &&
             (px.red_level < LowMax);
    yellow = !red && !green && (px.blue_level < YelBlueMax) &&
             (px.green_level >= HighMin) && (px.red_level >= HighMin);

    entry_o.row       = px.pixel_row;
    entry_o.col       = px.pixel_col;
    entry_o.is_red    = in_img && red;
    entry_o.is_green  = in_img && green;
    entry_o.is_yellow = in_img && yellow;
    entry_o.is_pink   = in_img && (px.blue_level >= PinkMin) &&
                        (px.green_level < PinkGreenMax) && (px.red_level >= PinkMin);
    entry_o.last      = px.frame_end;
  end

endmodule

FILE: hw/rtl/cmet_queue.sv
// ----------------------------------------------------------------------------
// cmet_queue
// Short request queue decoupling the classifier from the tracker.
// ----------------------------------------------------------------------------
module cmet_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cmet_pkg::entry_t  entry_i,
  output cmet_pkg::q_stat_t stat_o,
  output logic              valid_o,
  input  logic              ready_i,
  output cmet_pkg::entry_t  entry_o
);
  import cmet_pkg::*;

  entry_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             pop;

  assign valid_o      = (cnt_q != '0);
  assign pop          = valid_o && ready_i;
  assign entry_o      = mem_q[rd_q];
  assign stat_o.count = cnt_q;
  assign stat_o.full  = (cnt_q == QCntW'(QDepth));

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

FILE: hw/rtl/cmet_back.sv
// ----------------------------------------------------------------------------
// cmet_back
// Track colour order and extents; emit and clear at frame end.
// ----------------------------------------------------------------------------
module cmet_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  cmet_pkg::entry_t entry_i,
  output logic             ready_o,
  cmet_res_if.source       res_o
);
  import cmet_pkg::*;

  stage_e  stage_q, stage_d;
  coord_t  red_top_q, red_top_d, red_right_q, red_right_d;
  coord_t  grn_first_q, grn_first_d, grn_left_q, grn_left_d, grn_bot_q, grn_bot_d;
  coord_t  yel_top_q, yel_top_d, yel_right_q, yel_right_d;
  coord_t  pnk_first_q, pnk_first_d, pnk_left_q, pnk_left_d, pnk_bot_q, pnk_bot_d;
  result_t res_q, res_d;
  logic    res_valid_q, res_valid_d;
  logic    pop;

  // A last request needs the result register free; others always go
  assign ready_o     = !entry_i.last || !res_valid_q || res_o.ready;
  assign pop         = valid_i && ready_o;
  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  always_comb begin
    stage_d     = stage_q;
    red_top_d   = red_top_q;
    red_right_d = red_right_q;
    grn_first_d = grn_first_q;
    grn_left_d  = grn_left_q;
    grn_bot_d   = grn_bot_q;
    yel_top_d   = yel_top_q;
    yel_right_d = yel_right_q;
    pnk_first_d = pnk_first_q;
    pnk_left_d  = pnk_left_q;
    pnk_bot_d   = pnk_bot_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_o.ready;

    if (pop) begin
      if (entry_i.is_red) begin
        if (stage_d == StageNone) begin
          stage_d   = StageRed;
          red_top_d = entry_i.row;
        end
        if (red_right_d < entry_i.col) red_right_d = entry_i.col;
      end
      if (entry_i.is_green) begin
        if (stage_d == StageRed) begin
          stage_d     = StageGreen;
          grn_first_d = entry_i.row;
          grn_left_d  = entry_i.col;
        end
        if (entry_i.col < grn_left_d) grn_left_d = entry_i.col;
        if (grn_first_d < entry_i.row) grn_bot_d = entry_i.row;
      end
      if (entry_i.is_yellow) begin
        if (stage_d == StageGreen) begin
          stage_d   = StageYellow;
          yel_top_d = entry_i.row;
        end
        if (yel_right_d < entry_i.col) yel_right_d = entry_i.col;
      end
      if (entry_i.is_pink) begin
        if (stage_d == StageYellow) begin
          stage_d     = StagePink;
          pnk_first_d = entry_i.row;
          pnk_left_d  = entry_i.col;
        end
        if (entry_i.col < pnk_left_d) pnk_left_d = entry_i.col;
        if (pnk_first_d < entry_i.row) pnk_bot_d = entry_i.row;
      end

      if (entry_i.last) begin
        res_d.red_right_col    = red_right_d;
        res_d.red_top_row      = red_top_d;
        res_d.green_left_col   = grn_left_d;
        res_d.green_bottom_row = grn_bot_d;
        res_d.yellow_right_col = yel_right_d;
        res_d.yellow_top_row   = yel_top_d;
        res_d.pink_left_col    = pnk_left_d;
        res_d.pink_bottom_row  = pnk_bot_d;
        res_d.stage_reached    = StageW'(stage_d);
        res_valid_d            = 1'b1;
        // Clear for the next frame
        stage_d     = StageNone;
        red_top_d   = '0;
        red_right_d = '0;
        grn_first_d = '0;
        grn_left_d  = '0;
        grn_bot_d   = '0;
        yel_top_d   = '0;
        yel_right_d = '0;
        pnk_first_d = '0;
        pnk_left_d  = '0;
        pnk_bot_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= StageNone;
      red_top_q   <= '0;
      red_right_q <= '0;
      grn_first_q <= '0;
      grn_left_q  <= '0;
      grn_bot_q   <= '0;
      yel_top_q   <= '0;
      yel_right_q <= '0;
      pnk_first_q <= '0;
      pnk_left_q  <= '0;
      pnk_bot_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      stage_q     <= stage_d;
      red_top_q   <= red_top_d;
      red_right_q <= red_right_d;
      grn_first_q <= grn_first_d;
      grn_left_q  <= grn_left_d;
      grn_bot_q   <= grn_bot_d;
      yel_top_q   <= yel_top_d;
      yel_right_q <= yel_right_d;
      pnk_first_q <= pnk_first_d;
      pnk_left_q  <= pnk_left_d;
      pnk_bot_q   <= pnk_bot_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

FILE: hw/rtl/color_marker_extent_tracker.sv
// ----------------------------------------------------------------------------
// color_marker_extent_tracker
// Colour marker order and extent tracking over a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i carries one BGR pixel request with its row, column and a frame_end
//   flag; res_o carries one extent result per frame, sent on the request
//   that has frame_end set. Both are valid/ready channels.
//   Throughput: one pixel request per cycle while the queue is not full. The
//   front classifies in the accept cycle; the back tracker registers its
//   extents as it takes each request. Result path: a frame_end request goes
//   through the two-entry queue, then the result register, to res_o.
//   Stall: while a result waits in the output register, non-final pixels
//   keep flowing; only a second frame_end waits in the queue, and the
//   queue backs up to pix_i.ready once both entries are held.
//   Reset: rst_ni clears the order stage, all extents, the queue and the
//   result valid flag; the block is ready once reset is released.
// ----------------------------------------------------------------------------
`include "color_marker_extent_tracker_assert.svh"

module color_marker_extent_tracker (
  input  logic       clk_i,
  input  logic       rst_ni,
  cmet_pix_if.sink   pix_i,
  cmet_res_if.source res_o
);
  import cmet_pkg::*;

  logic    push;
  entry_t  push_entry;
  q_stat_t q_stat;
  logic    q_valid;
  logic    q_ready;
  entry_t  q_entry;

  // Front: accept and classify
  cmet_front u_front (
    .pix_i   (pix_i),
    .stat_i  (q_stat),
    .push_o  (push),
    .entry_o (push_entry)
  );

  // Hold classified requests so each side may stall on its own
  cmet_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .stat_o  (q_stat),
    .valid_o (q_valid),
    .ready_i (q_ready),
    .entry_o (q_entry)
  );

  // Back: advance stage, track extents, emit at frame end
  cmet_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .entry_i (q_entry),
    .ready_o (q_ready),
    .res_o   (res_o)
  );

  `CMET_ASSERT_IMPL(a_q_bound, 1'b1, q_stat.count <= QCntW'(QDepth), "queue overfilled")
  `CMET_ASSERT_IMPL(a_full_block, q_stat.full, !pix_i.ready, "request taken while queue full")
  `CMET_ASSERT_NEXT(a_res_src, !res_o.valid && !(q_valid && q_ready && q_entry.last),
                    !res_o.valid, "result without frame end")
  `CMET_ASSERT_IMPL(a_stage_range, res_o.valid, res_o.data.stage_reached <= StageW'(StagePink),
                    "stage out of range")

endmodule
